/* rtl/core/dsm_pkg.sv */
// Package: payload types, SHA-256 constants and round helpers for the miner.
`default_nettype none
package dsm_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MID01  = 3'd0,
		REG_MID23  = 3'd1,
		REG_MID45  = 3'd2,
		REG_MID67  = 3'd3,
		REG_FILTER = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] tail_word_0;
		logic [31:0] tail_word_1;
		logic [31:0] tail_word_2;
		logic [31:0] tail_word_3;
	} tail_t;

	typedef struct packed {
		logic [31:0] hash_word_0;
		logic [31:0] hash_word_1;
		logic [31:0] hash_word_2;
		logic [31:0] hash_word_3;
		logic [31:0] hash_word_4;
		logic [31:0] hash_word_5;
		logic [31:0] hash_word_6;
		logic [31:0] hash_word_7;
		logic        is_candidate;
	} hash_t;

	typedef logic [7:0][31:0]  state8_t;
	typedef logic [15:0][31:0] sched_t;

	localparam logic [31:0] PadWord = 32'h80000000;
	localparam logic [31:0] Len640  = 32'd640;
	localparam logic [31:0] Len256  = 32'd256;

	localparam state8_t InitH = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam logic [63:0][31:0] RoundK = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one compression round; w is the schedule word for this round
	function automatic state8_t sha_round(input state8_t v, input logic [31:0] k,
			input logic [31:0] w);
		logic [31:0] t1;
		logic [31:0] t2;
		state8_t     o;
		t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
			+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
		t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
			+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		o[7] = v[6]; o[6] = v[5]; o[5] = v[4];
		o[4] = v[3] + t1;
		o[3] = v[2]; o[2] = v[1]; o[1] = v[0];
		o[0] = t1 + t2;
		return o;
	endfunction

	// slide the 16-word schedule window by one word
	function automatic sched_t sched_next(input sched_t w);
		logic [31:0] s0;
		logic [31:0] s1;
		sched_t      o;
		s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
		s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
		for (int i = 0; i < 15; i++) o[i] = w[i+1];
		o[15] = w[0] + s0 + w[9] + s1;
		return o;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/double_sha256_midstate_miner.sv */
// Top level: config registers, two chained compressions, candidate filter.
//
// Usage: write midstate words (index 0..3) and filter_enable (index 4) through
// cfg_we/cfg_idx/cfg_data while idle. Present the four tail words on tail with
// start high; since busy is always low, one beat is taken every cycle.
// Each compression is 64 round registers plus one feed-forward register, with
// one register at the output: one item per cycle throughput.
// A result beat shows on result for exactly one cycle with done high; with
// filtering on, non-candidates produce no beat. Results leave in input order.
// The receiver has no way to stall, and none is needed.
// Reset clears all valid bits, the midstate to zero and sets filter_enable.
// Midstate is sampled at entry but filter_enable at the output, so writes
// must wait until the pipe drains.
`default_nettype none
module double_sha256_midstate_miner
	import dsm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire tail_t               tail,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_idx,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output logic                     done,
	output hash_t                    result
);
	logic [3:0][63:0] mid_q;
	logic filter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q    <= '0;
			filter_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MID01:  mid_q[0] <= cfg_data;
				REG_MID23:  mid_q[1] <= cfg_data;
				REG_MID45:  mid_q[2] <= cfg_data;
				REG_MID67:  mid_q[3] <= cfg_data;
				REG_FILTER: filter_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	state8_t mid_h;
	sched_t blk1;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mid_h[2*i]   = mid_q[i][63:32];
			mid_h[2*i+1] = mid_q[i][31:0];
		end
		blk1     = '0;
		blk1[0]  = tail.tail_word_0;
		blk1[1]  = tail.tail_word_1;
		blk1[2]  = tail.tail_word_2;
		blk1[3]  = tail.tail_word_3;
		blk1[4]  = PadWord;
		blk1[15] = Len640;
	end

	logic v1;
	state8_t d1;
	logic unused_side1;
	dsm_compress #(.SideW(1)) u_first (
		.clk(clk), .arst_n(arst_n), .valid_in(start), .chain_in(mid_h),
		.block_in(blk1), .side_in(1'b0), .valid_out(v1), .digest_out(d1),
		.side_out(unused_side1)
	);

	sched_t blk2;
	always_comb begin
		blk2 = '0;
		for (int i = 0; i < 8; i++) blk2[i] = d1[i];
		blk2[8]  = PadWord;
		blk2[15] = Len256;
	end

	logic v2;
	state8_t d2;
	logic side2;
	dsm_compress #(.SideW(1)) u_second (
		.clk(clk), .arst_n(arst_n), .valid_in(v1), .chain_in(InitH),
		.block_in(blk2), .side_in(unused_side1), .valid_out(v2), .digest_out(d2),
		.side_out(side2)
	);

	logic cand;
	assign cand = (d2[7][31:16] == 16'h0000);

	logic done_q;
	hash_t res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v2 && (cand || !filter_q) && !side2;
	end

	always_ff @(posedge clk) begin
		res_q <= {d2[0], d2[1], d2[2], d2[3], d2[4], d2[5], d2[6], d2[7], cand};
	end

	assign done   = done_q;
	assign result = res_q;

	a_cand_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_candidate == (result.hash_word_7[31:16] == 16'h0000)))
		else $error("candidate flag mismatch");
	a_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(done && filter_q) |-> result.is_candidate)
		else $error("non-candidate passed filter");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v2))
		else $error("result without valid digest");
endmodule
`default_nettype wire

/* rtl/core/dsm_round_stage.sv */
// One registered SHA-256 round with schedule window and side payload.
`default_nettype none
module dsm_round_stage
	import dsm_pkg::*;
#(
	parameter int unsigned Round = 0,
	parameter int unsigned SideW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire state8_t          v_in,
	input  wire sched_t           w_in,
	input  wire logic [SideW-1:0] side_in,
	output logic                  valid_out,
	output state8_t               v_out,
	output sched_t                w_out,
	output logic [SideW-1:0]      side_out
);
	logic valid_s1;
	state8_t v_s1;
	sched_t w_s1;
	logic [SideW-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= valid_in;
	end

	always_ff @(posedge clk) begin
		v_s1    <= sha_round(v_in, RoundK[Round], w_in[0]);
		w_s1    <= sched_next(w_in);
		side_s1 <= side_in;
	end

	assign valid_out = valid_s1;
	assign v_out     = v_s1;
	assign w_out     = w_s1;
	assign side_out  = side_s1;
endmodule
`default_nettype wire

/* rtl/core/dsm_compress.sv */
// Unrolled 64-round SHA-256 compression, one register per round, feed-forward add.
`default_nettype none
module dsm_compress
	import dsm_pkg::*;
#(
	parameter int unsigned SideW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire state8_t          chain_in,
	input  wire sched_t           block_in,
	input  wire logic [SideW-1:0] side_in,
	output logic                  valid_out,
	output state8_t               digest_out,
	output logic [SideW-1:0]      side_out
);
	localparam int unsigned CarryW = SideW + 256;

	logic    [64:0] vld;
	state8_t [64:0] vst;
	sched_t  [64:0] wst;
	logic    [64:0][CarryW-1:0] sst;

	assign vld[0] = valid_in;
	assign vst[0] = chain_in;
	assign wst[0] = block_in;
	assign sst[0] = {side_in, chain_in};

	for (genvar r = 0; r < 64; r++) begin : g_rnd
		dsm_round_stage #(.Round(r), .SideW(CarryW)) u_rnd (
			.clk(clk), .arst_n(arst_n),
			.valid_in(vld[r]), .v_in(vst[r]), .w_in(wst[r]), .side_in(sst[r]),
			.valid_out(vld[r+1]), .v_out(vst[r+1]), .w_out(wst[r+1]),
			.side_out(sst[r+1])
		);
	end

	logic valid_s1;
	state8_t dig_s1;
	logic [SideW-1:0] side_s1;
	state8_t chain_end;

	assign chain_end = sst[64][255:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= vld[64];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++) dig_s1[i] <= chain_end[i] + vst[64][i];
		side_s1 <= sst[64][CarryW-1:256];
	end

	assign valid_out  = valid_s1;
	assign digest_out = dig_s1;
	assign side_out   = side_s1;
endmodule
`default_nettype wire
